@@ hw/rtl/pct_pkg.sv @@
package pct_pkg;

  // input actions
  localparam logic [1:0] ACT_WRITE_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_RECALL       = 2'd1;
  localparam logic [1:0] ACT_TRAIN        = 2'd2;
  localparam logic [1:0] ACT_END_EPOCH    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_INPUT_COUNT   = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT  = 2'd2;

  // configuration reset values
  localparam logic [15:0] LEARNING_RATE_RST = 16'd13107;
  localparam logic [4:0]  INPUT_COUNT_RST   = 5'd16;
  localparam logic [3:0]  OUTPUT_COUNT_RST  = 4'd8;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EPOCH  = 1'b1;

  // Q15.16 weight limits in the widened update format
  localparam logic signed [33:0] W_MAX = 34'sd2147483647;
  localparam logic signed [33:0] W_MIN = -34'sd2147483648;

  typedef struct packed {
    logic valid;
    logic upd;
    logic bias;
    logic err_neg;
  } s1_ctl_t;

  typedef struct packed {
    logic we;
    logic changed;
  } wb_ctl_t;

endpackage

@@ hw/rtl/perceptron_train_and_recall.sv @@
// Single-layer perceptron, recall and training.
// Input channel: an item is taken on a clock edge with start high and busy low.
// A weight write or a feature that is not the last of a sample leaves busy
// low. An end of epoch gives its result in the cycle after it is taken. The
// last feature of a sample starts a pass over the neurons in use: each neuron
// streams its nin weights and the bias through the weight memory port and one
// multiplier, one per cycle; a training neuron whose output misses its target
// then reads, updates and writes back its row in a second pass. The sample
// result appears in the cycle after the last neuron finishes, and busy stays
// high until then.
// Results are shown on the out_ ports for one cycle with out_valid high; the
// receiver cannot hold them off, so none is ever stalled.
// Configuration writes are taken in any cycle and have no result.
// After reset the weight memory is cleared, one entry a cycle, with busy high.
module perceptron_train_and_recall #(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_neuron_index,
  input  logic [4:0]         in_weight_column,
  input  logic signed [31:0] in_weight_value,
  input  logic signed [15:0] in_feature_value,
  input  logic [7:0]         in_target_bits,
  input  logic               in_last,
  output logic               out_valid,
  output logic               out_result_kind,
  output logic [7:0]         out_activations,
  output logic               out_matches_target,
  output logic               out_weights_changed,
  output logic               out_epoch_converged,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pct_pkg::*;

  localparam int ROW_LEN = MAX_INPUTS + 1;
  localparam int DEPTH   = MAX_OUTPUTS * ROW_LEN;
  localparam int WA_W    = $clog2(DEPTH);
  localparam int KC_W    = $clog2(MAX_INPUTS + 1);
  localparam int FI_W    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NO_W    = $clog2(MAX_OUTPUTS + 1);
  localparam int ACC_W   = 49 + $clog2(MAX_INPUTS + 1);

  localparam logic [2:0] PH_CLEAR    = 3'd0;
  localparam logic [2:0] PH_IDLE     = 3'd1;
  localparam logic [2:0] PH_MAC      = 3'd2;
  localparam logic [2:0] PH_MAC_END  = 3'd3;
  localparam logic [2:0] PH_UPD      = 3'd4;
  localparam logic [2:0] PH_UPD_END  = 3'd5;

  logic [15:0]        cfg_lr_r;
  logic [4:0]         cfg_nin_r;
  logic [3:0]         cfg_nout_r;
  logic [KC_W-1:0]    nin;
  logic [NO_W-1:0]    nout;

  logic [2:0]         phase_r, phase_nxt;
  logic [WA_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [KC_W-1:0]    k_r, k_nxt;
  logic [NO_W-1:0]    j_r, j_nxt;
  logic [WA_W-1:0]    row_r, row_nxt;
  logic [7:0]         act_r, act_nxt;
  logic               chg_r, chg_nxt;
  logic               err_neg_r, err_neg_nxt;
  logic               train_r, train_nxt;
  logic [7:0]         target_r, target_nxt;
  logic               epoch_chg_r, epoch_chg_nxt;
  logic [KC_W-1:0]    fcnt_r, fcnt_nxt;

  logic               s1_v_r;
  logic               s1_upd_r;
  logic               s1_bias_r;
  logic [WA_W-1:0]    s1_addr_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [7:0]         out_act_r;
  logic               out_match_r;
  logic               out_chg_r;
  logic               out_conv_r;

  logic signed [31:0] wmem [DEPTH];
  logic signed [15:0] fmem [MAX_INPUTS];
  logic signed [31:0] w_rd_r;
  logic signed [15:0] f_rd_r;

  logic               issue;
  logic               at_bias;
  logic [WA_W-1:0]    w_raddr;
  logic [FI_W-1:0]    f_raddr;
  logic               wm_we;
  logic [WA_W-1:0]    wm_addr;
  logic signed [31:0] wm_data;
  logic               fm_we;
  logic               wr_ok;
  logic [WA_W-1:0]    wr_addr;
  logic               acc_clr;
  logic               report;
  logic               epoch_beat;
  logic               next_neuron;
  logic               neuron_act;
  logic               t_bit;
  logic [7:0]         mask;

  s1_ctl_t            s1_ctl;
  wb_ctl_t            wb_ctl;
  logic signed [ACC_W-1:0] acc;
  logic               s2_valid;
  logic [WA_W-1:0]    wb_addr;
  logic signed [31:0] wb_data;

  // clamp the counts between one and the sizes that the memories hold
  always_comb begin
    if (cfg_nin_r == 5'd0) begin
      nin = KC_W'(1);
    end else if (int'(cfg_nin_r) > MAX_INPUTS) begin
      nin = KC_W'(MAX_INPUTS);
    end else begin
      nin = KC_W'(cfg_nin_r);
    end
    if (cfg_nout_r == 4'd0) begin
      nout = NO_W'(1);
    end else if (int'(cfg_nout_r) > MAX_OUTPUTS) begin
      nout = NO_W'(MAX_OUTPUTS);
    end else begin
      nout = NO_W'(cfg_nout_r);
    end
    for (int b = 0; b < 8; b++) begin
      mask[b] = (b < int'(nout));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lr_r   <= LEARNING_RATE_RST;
      cfg_nin_r  <= INPUT_COUNT_RST;
      cfg_nout_r <= OUTPUT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE: cfg_lr_r   <= cfg_data;
        REG_INPUT_COUNT:   cfg_nin_r  <= cfg_data[4:0];
        REG_OUTPUT_COUNT:  cfg_nout_r <= cfg_data[3:0];
        default:           ;
      endcase
    end
  end

  // weight write address; the bias sits in the slot after the feature slots
  always_comb begin
    wr_ok   = (int'(in_neuron_index) < MAX_OUTPUTS) &&
              (int'(in_weight_column) <= int'(nin));
    wr_addr = WA_W'(int'(in_neuron_index) * ROW_LEN +
                    ((int'(in_weight_column) == int'(nin)) ? MAX_INPUTS
                                                           : int'(in_weight_column)));
  end

  assign issue   = (phase_r == PH_MAC) || (phase_r == PH_UPD);
  assign at_bias = (k_r == nin);
  assign w_raddr = row_r + (at_bias ? WA_W'(MAX_INPUTS) : WA_W'(k_r));
  assign f_raddr = at_bias ? '0 : k_r[FI_W-1:0];

  assign neuron_act = !acc[ACC_W-1] && (acc != '0);
  assign epoch_beat = (phase_r == PH_IDLE) && start && (in_action == ACT_END_EPOCH);

  always_comb begin
    phase_nxt     = phase_r;
    clr_addr_nxt  = clr_addr_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    row_nxt       = row_r;
    act_nxt       = act_r;
    chg_nxt       = chg_r;
    err_neg_nxt   = err_neg_r;
    train_nxt     = train_r;
    target_nxt    = target_r;
    epoch_chg_nxt = epoch_chg_r;
    fcnt_nxt      = fcnt_r;
    acc_clr       = 1'b0;
    report        = 1'b0;
    next_neuron   = 1'b0;
    wm_we         = 1'b0;
    wm_addr       = wr_addr;
    wm_data       = in_weight_value;
    fm_we         = 1'b0;
    t_bit         = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (int'(j_r) == b) t_bit = target_r[b];
    end

    if (wb_ctl.we) begin
      wm_we   = 1'b1;
      wm_addr = wb_addr;
      wm_data = wb_data;
      if (wb_ctl.changed) chg_nxt = 1'b1;
    end

    case (phase_r)
      PH_CLEAR: begin
        wm_we   = 1'b1;
        wm_addr = clr_addr_r;
        wm_data = '0;
        if (clr_addr_r == WA_W'(DEPTH - 1)) begin
          phase_nxt = PH_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + WA_W'(1);
        end
      end
      PH_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_WRITE_WEIGHT: begin
              if (wr_ok) wm_we = 1'b1;
            end
            ACT_END_EPOCH: begin
              epoch_chg_nxt = 1'b0;
              fcnt_nxt      = '0;
            end
            default: begin
              // saturate the count: extra features are dropped
              if (int'(fcnt_r) < MAX_INPUTS) begin
                fm_we    = 1'b1;
                fcnt_nxt = fcnt_r + KC_W'(1);
              end
              if (in_last) begin
                fcnt_nxt   = '0;
                phase_nxt  = PH_MAC;
                k_nxt      = '0;
                j_nxt      = '0;
                row_nxt    = '0;
                act_nxt    = '0;
                chg_nxt    = 1'b0;
                train_nxt  = (in_action == ACT_TRAIN);
                target_nxt = in_target_bits;
                acc_clr    = 1'b1;
              end
            end
          endcase
        end
      end
      PH_MAC, PH_UPD: begin
        if (at_bias) begin
          phase_nxt = (phase_r == PH_MAC) ? PH_MAC_END : PH_UPD_END;
        end else begin
          k_nxt = k_r + KC_W'(1);
        end
      end
      PH_MAC_END: begin
        // wait for the sum to drain out of the pipeline
        if (!s1_v_r && !s2_valid) begin
          for (int b = 0; b < 8; b++) begin
            if (int'(j_r) == b) act_nxt[b] = neuron_act;
          end
          if (train_r && (t_bit != neuron_act)) begin
            err_neg_nxt = neuron_act;
            phase_nxt   = PH_UPD;
            k_nxt       = '0;
          end else begin
            next_neuron = 1'b1;
          end
        end
      end
      PH_UPD_END: begin
        if (!s1_v_r && !s2_valid) next_neuron = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (next_neuron) begin
      if (j_r + NO_W'(1) == nout) begin
        report        = 1'b1;
        phase_nxt     = PH_IDLE;
        epoch_chg_nxt = epoch_chg_r | chg_r;
      end else begin
        j_nxt     = j_r + NO_W'(1);
        row_nxt   = row_r + WA_W'(ROW_LEN);
        k_nxt     = '0;
        acc_clr   = 1'b1;
        phase_nxt = PH_MAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAR;
      clr_addr_r  <= '0;
      k_r         <= '0;
      j_r         <= '0;
      row_r       <= '0;
      act_r       <= '0;
      chg_r       <= 1'b0;
      err_neg_r   <= 1'b0;
      train_r     <= 1'b0;
      epoch_chg_r <= 1'b0;
      fcnt_r      <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      clr_addr_r  <= clr_addr_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      row_r       <= row_nxt;
      act_r       <= act_nxt;
      chg_r       <= chg_nxt;
      err_neg_r   <= err_neg_nxt;
      train_r     <= train_nxt;
      epoch_chg_r <= epoch_chg_nxt;
      fcnt_r      <= fcnt_nxt;
      s1_v_r      <= issue;
      out_valid_r <= report || epoch_beat;
    end
    target_r  <= target_nxt;
    s1_upd_r  <= (phase_r == PH_UPD);
    s1_bias_r <= at_bias;
    s1_addr_r <= w_raddr;
    if (epoch_beat) begin
      out_kind_r  <= KIND_EPOCH;
      out_act_r   <= '0;
      out_match_r <= 1'b0;
      out_chg_r   <= 1'b0;
      out_conv_r  <= !epoch_chg_r;
    end else begin
      out_kind_r  <= KIND_SAMPLE;
      out_act_r   <= act_nxt;
      out_match_r <= ((act_nxt & mask) == (target_r & mask));
      out_chg_r   <= chg_r;
      out_conv_r  <= 1'b0;
    end
  end

  // weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wm_we) wmem[wm_addr] <= wm_data;
    w_rd_r <= wmem[w_raddr];
  end

  // feature buffer
  always_ff @(posedge clk) begin
    if (fm_we) fmem[fcnt_r[FI_W-1:0]] <= in_feature_value;
    f_rd_r <= fmem[f_raddr];
  end

  assign s1_ctl.valid   = s1_v_r;
  assign s1_ctl.upd     = s1_upd_r;
  assign s1_ctl.bias    = s1_bias_r;
  assign s1_ctl.err_neg = err_neg_r;

  pct_arith #(
    .ACC_W (ACC_W),
    .WA_W  (WA_W)
  ) u_arith (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_ctl     (s1_ctl),
    .s1_addr    (s1_addr_r),
    .s1_weight  (w_rd_r),
    .s1_feature (f_rd_r),
    .eta        (cfg_lr_r),
    .acc_clr    (acc_clr),
    .acc        (acc),
    .s2_valid   (s2_valid),
    .wb_ctl     (wb_ctl),
    .wb_addr    (wb_addr),
    .wb_data    (wb_data)
  );

  assign busy                = (phase_r != PH_IDLE);
  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_activations     = out_act_r;
  assign out_matches_target  = out_match_r;
  assign out_weights_changed = out_chg_r;
  assign out_epoch_converged = out_conv_r;

  a_wb_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    wb_ctl.we |-> (phase_r == PH_UPD || phase_r == PH_UPD_END))
    else $error("weight write-back outside an update pass");

  a_sample_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SAMPLE) |->
      ($past(phase_r) == PH_MAC_END || $past(phase_r) == PH_UPD_END))
    else $error("sample result without a finished neuron pass");

  a_clr_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clr |-> !s2_valid)
    else $error("accumulator cleared while a product is in flight");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE && $past(phase_r) == PH_CLEAR) |->
      ($past(clr_addr_r) == WA_W'(DEPTH - 1)))
    else $error("clearing pass ended early");

endmodule

@@ hw/rtl/pct_arith.sv @@
module pct_arith #(
  parameter int ACC_W = 53,
  parameter int WA_W  = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pct_pkg::s1_ctl_t        s1_ctl,
  input  logic [WA_W-1:0]         s1_addr,
  input  logic signed [31:0]      s1_weight,
  input  logic signed [15:0]      s1_feature,
  input  logic [15:0]             eta,
  input  logic                    acc_clr,
  output logic signed [ACC_W-1:0] acc,
  output logic                    s2_valid,
  output pct_pkg::wb_ctl_t        wb_ctl,
  output logic [WA_W-1:0]         wb_addr,
  output logic signed [31:0]      wb_data
);
  import pct_pkg::*;

  logic signed [16:0]      x_ext;
  logic signed [16:0]      x_abs;
  logic signed [16:0]      b_op;
  logic signed [32:0]      a_op;
  logic signed [49:0]      prod;
  logic                    s1_neg;

  logic                    s2_v_r;
  logic                    s2_upd_r;
  logic                    s2_neg_r;
  logic signed [49:0]      prod_r;
  logic [WA_W-1:0]         s2_addr_r;
  logic signed [31:0]      s2_w_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [32:0]             m_round;
  logic [24:0]             mag;
  logic signed [33:0]      step;
  logic signed [33:0]      sum34;
  logic signed [33:0]      sat;

  // stage 1: one shared multiplier, w*x for the sum or eta*|x| for the step
  always_comb begin
    x_ext = {s1_feature[15], s1_feature};
    x_abs = x_ext[16] ? -x_ext : x_ext;
    if (s1_ctl.upd) begin
      a_op = $signed({17'd0, eta});
      // eta*256 rounds back to eta exactly
      b_op = s1_ctl.bias ? 17'sd256 : x_abs;
    end else begin
      a_op = {s1_weight[31], s1_weight};
      b_op = s1_ctl.bias ? -17'sd256 : x_ext;
    end
    prod = a_op * b_op;
    // bias input is -1, so its step has the opposite sign of the error
    s1_neg = s1_ctl.bias ? !s1_ctl.err_neg : (x_ext[16] ^ s1_ctl.err_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_ctl.valid;
    end
    prod_r    <= prod;
    s2_upd_r  <= s1_ctl.upd;
    s2_neg_r  <= s1_neg;
    s2_addr_r <= s1_addr;
    s2_w_r    <= s1_weight;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (s2_v_r && !s2_upd_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // stage 2: round the step, add and saturate
  always_comb begin
    m_round = {1'b0, prod_r[31:0]} + 33'd128;
    mag     = m_round[32:8];
    step    = s2_neg_r ? -$signed({9'd0, mag}) : $signed({9'd0, mag});
    sum34   = {{2{s2_w_r[31]}}, s2_w_r} + step;
    if (sum34 > W_MAX) begin
      sat = W_MAX;
    end else if (sum34 < W_MIN) begin
      sat = W_MIN;
    end else begin
      sat = sum34;
    end
  end

  assign acc            = acc_r;
  assign s2_valid       = s2_v_r;
  assign wb_ctl.we      = s2_v_r && s2_upd_r;
  assign wb_ctl.changed = (sat[31:0] != s2_w_r);
  assign wb_addr        = s2_addr_r;
  assign wb_data        = sat[31:0];

endmodule

@@ verif/perceptron_train_and_recall_tb.sv @@
`timescale 1ns / 100ps

module perceptron_train_and_recall_tb;
  import pct_pkg::*;

  localparam int     N_IN         = 16;
  localparam int     N_OUT        = 8;
  localparam int     BIAS_SLOT    = N_IN;
  localparam longint WGT_HI       = 64'sd2147483647;
  localparam longint WGT_LO       = -64'sd2147483648;
  localparam int     IDLE_SETTLE  = 4;
  localparam int     DRAIN_CYCLES = 400;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     CALM_TAIL    = 50;

  typedef struct {
    bit                 cfg;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic [1:0]         action;
    logic [2:0]         neuron;
    logic [4:0]         column;
    logic signed [31:0] weight;
    logic signed [15:0] feature;
    logic [7:0]         target;
    logic               last;
  } op_t;

  typedef struct {
    logic       kind;
    logic [7:0] act;
    logic       hit;
    logic       changed;
    logic       conv;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_action = '0;
  logic [2:0]         in_neuron_index = '0;
  logic [4:0]         in_weight_column = '0;
  logic signed [31:0] in_weight_value = '0;
  logic signed [15:0] in_feature_value = '0;
  logic [7:0]         in_target_bits = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_result_kind;
  logic [7:0]         out_activations;
  logic               out_matches_target;
  logic               out_weights_changed;
  logic               out_epoch_converged;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  perceptron_train_and_recall dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_neuron_index     (in_neuron_index),
    .in_weight_column    (in_weight_column),
    .in_weight_value     (in_weight_value),
    .in_feature_value    (in_feature_value),
    .in_target_bits      (in_target_bits),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_result_kind     (out_result_kind),
    .out_activations     (out_activations),
    .out_matches_target  (out_matches_target),
    .out_weights_changed (out_weights_changed),
    .out_epoch_converged (out_epoch_converged),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  op_t      cmd_q[$];
  outcome_t pending_outcomes[$];
  int       errors = 0;
  bit       beat_taken = 1'b0;
  int       gap_left = 0;
  int       quiet = 0;

  // shadow of the block
  logic signed [31:0] w_mem [N_OUT][N_IN+1];
  logic signed [15:0] x_buf [N_IN];
  int                 x_count;
  bit                 epoch_dirty;
  logic [15:0]        eta;
  logic [4:0]         in_cnt_reg;
  logic [3:0]         out_cnt_reg;

  // stimulus-side view of the feature buffer, so no unwritten slot is ever read
  int gen_nin;
  int gen_fcount;
  int gen_hi;

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit bump_weight(int j, int k, longint step);
    longint old_w, new_w;
    old_w = w_mem[j][k];
    new_w = old_w + step;
    if (new_w > WGT_HI) new_w = WGT_HI;
    if (new_w < WGT_LO) new_w = WGT_LO;
    w_mem[j][k] = new_w[31:0];
    return new_w != old_w;
  endfunction

  task automatic predict_beat(input op_t op);
    int         nin, nout, slot;
    longint     acc, x, mag, err;
    logic [7:0] act, mask;
    bit         changed;
    outcome_t   o;
    nin = clamp_count(int'(in_cnt_reg), N_IN);
    nout = clamp_count(int'(out_cnt_reg), N_OUT);
    o = '{default: '0};
    case (op.action)
      ACT_WRITE_WEIGHT: begin
        if (int'(op.column) <= nin) begin
          slot = (int'(op.column) == nin) ? BIAS_SLOT : int'(op.column);
          w_mem[op.neuron][slot] = op.weight;
        end
      end
      ACT_END_EPOCH: begin
        o.kind = KIND_EPOCH;
        o.conv = !epoch_dirty;
        epoch_dirty = 1'b0;
        x_count = 0;
        pending_outcomes.push_back(o);
      end
      default: begin
        if (x_count < N_IN) begin
          x_buf[x_count] = op.feature;
          x_count++;
        end
        if (op.last) begin
          x_count = 0;
          act = '0;
          mask = '0;
          changed = 1'b0;
          for (int j = 0; j < nout; j++) begin
            acc = -longint'(w_mem[j][BIAS_SLOT]) * 256;
            for (int k = 0; k < nin; k++)
              acc += longint'(w_mem[j][k]) * longint'(x_buf[k]);
            mask[j] = 1'b1;
            if (acc > 0) act[j] = 1'b1;
          end
          if (op.action == ACT_TRAIN) begin
            for (int j = 0; j < nout; j++) begin
              err = longint'(op.target[j]) - longint'(act[j]);
              if (err != 0) begin
                for (int k = 0; k < nin; k++) begin
                  x = x_buf[k];
                  // round |x|*eta from Q7.24 to Q15.16, ties away from zero
                  mag = ((x < 0 ? -x : x) * longint'(eta) + 128) >>> 8;
                  if (bump_weight(j, k, err * (x < 0 ? -mag : mag))) changed = 1'b1;
                end
                if (bump_weight(j, BIAS_SLOT, -err * longint'(eta))) changed = 1'b1;
              end
            end
            if (changed) epoch_dirty = 1'b1;
          end
          o.kind = KIND_SAMPLE;
          o.act = act;
          o.hit = ((act & mask) == (op.target & mask));
          o.changed = changed;
          pending_outcomes.push_back(o);
        end
      end
    endcase
  endtask

  function automatic op_t noise_op();
    op_t op;
    op.cfg = 1'b0;
    op.cfg_index = '0;
    op.cfg_data = '0;
    op.action = 2'($urandom);
    op.neuron = 3'($urandom);
    op.column = 5'($urandom);
    op.weight = $urandom;
    op.feature = 16'($urandom);
    op.target = 8'($urandom);
    op.last = 1'($urandom);
    return op;
  endfunction

  function automatic logic [15:0] rand_feature();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 1 << 20) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cfg(logic [1:0] idx, logic [15:0] data);
    op_t op;
    op = noise_op();
    op.cfg = 1'b1;
    op.cfg_index = idx;
    op.cfg_data = data;
    cmd_q.push_back(op);
    if (idx == REG_INPUT_COUNT) gen_nin = clamp_count(int'(data[4:0]), N_IN);
  endtask

  task automatic push_weight(int n, int c, logic [31:0] v);
    op_t op;
    op = noise_op();
    op.action = ACT_WRITE_WEIGHT;
    op.neuron = 3'(n);
    op.column = 5'(c);
    op.weight = v;
    cmd_q.push_back(op);
  endtask

  task automatic push_epoch();
    op_t op;
    op = noise_op();
    op.action = ACT_END_EPOCH;
    cmd_q.push_back(op);
    gen_fcount = 0;
  endtask

  // pad a closing feature with fillers while some slot in use was never written
  task automatic push_feature(logic [1:0] act, logic [15:0] x, logic [7:0] tgt, bit lst);
    op_t op;
    bit  pad;
    int  reach;
    do begin
      reach = (gen_fcount + 1 > gen_hi) ? gen_fcount + 1 : gen_hi;
      pad = lst && (reach < gen_nin);
      op = noise_op();
      op.action = act;
      op.last = lst && !pad;
      if (!pad) begin
        op.feature = x;
        op.target = tgt;
      end
      cmd_q.push_back(op);
      if (gen_fcount < N_IN) gen_fcount++;
      if (gen_fcount > gen_hi) gen_hi = gen_fcount;
      if (op.last) gen_fcount = 0;
    end while (pad);
  endtask

  task automatic push_sample(logic [1:0] mode, int len);
    logic [1:0] act;
    for (int i = 0; i < len; i++) begin
      act = mode;
      if (i != len - 1 && $urandom_range(0, 9) == 0)
        act = (mode == ACT_TRAIN) ? ACT_RECALL : ACT_TRAIN;
      push_feature(act, rand_feature(), 8'($urandom), i == len - 1);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin : drive_beats
    op_t  op;
    logic nx_start, nx_we;
    nx_start = start;
    nx_we = 1'b0;
    if (pending_outcomes.size() == 0 && !busy && !start) quiet++;
    else quiet = 0;
    // hold a beat until it is taken
    if (rst_n && !(start && !beat_taken)) begin
      beat_taken = 1'b0;
      nx_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        if (!cmd_q[0].cfg) begin
          op = cmd_q.pop_front();
          nx_start = 1'b1;
          in_action <= op.action;
          in_neuron_index <= op.neuron;
          in_weight_column <= op.column;
          in_weight_value <= op.weight;
          in_feature_value <= op.feature;
          in_target_bits <= op.target;
          in_last <= op.last;
          if (cmd_q.size() > CALM_TAIL && (cmd_q.size() / 64) % 3 != 0 &&
              $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 5);
        end else if (quiet >= IDLE_SETTLE) begin
          op = cmd_q.pop_front();
          nx_we = 1'b1;
          cfg_index <= op.cfg_index;
          cfg_data <= op.cfg_data;
        end
      end
    end
    start <= nx_start;
    cfg_we <= nx_we;
  end

  always @(posedge clk) begin : watch_ports
    outcome_t got, want;
    op_t      seen;
    if (rst_n) begin
      // match results before predicting a beat taken at this same edge
      if (out_valid) begin
        got = '{out_result_kind, out_activations, out_matches_target,
                out_weights_changed, out_epoch_converged};
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result expected none actual kind=%0d act=%h hit=%0d chg=%0d conv=%0d",
                   $time, got.kind, got.act, got.hit, got.changed, got.conv);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(got.kind));
          check_field("activations", want.act, got.act);
          check_field("matches_target", 8'(want.hit), 8'(got.hit));
          check_field("weights_changed", 8'(want.changed), 8'(got.changed));
          check_field("epoch_converged", 8'(want.conv), 8'(got.conv));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: eta = cfg_data;
          REG_INPUT_COUNT:   in_cnt_reg = cfg_data[4:0];
          REG_OUTPUT_COUNT:  out_cnt_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen = noise_op();
        seen.action = in_action;
        seen.neuron = in_neuron_index;
        seen.column = in_weight_column;
        seen.weight = in_weight_value;
        seen.feature = in_feature_value;
        seen.target = in_target_bits;
        seen.last = in_last;
        predict_beat(seen);
        beat_taken = 1'b1;
      end
    end
  end

  initial begin : run_limit
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_flow
    logic [15:0] r16;
    logic [15:0] rate;
    logic [4:0]  nin_raw;
    int          phase_end, pick;

    eta = LEARNING_RATE_RST;
    in_cnt_reg = INPUT_COUNT_RST;
    out_cnt_reg = OUTPUT_COUNT_RST;
    for (int j = 0; j < N_OUT; j++)
      for (int k = 0; k <= N_IN; k++) w_mem[j][k] = '0;
    for (int k = 0; k < N_IN; k++) x_buf[k] = '0;
    x_count = 0;
    epoch_dirty = 1'b0;
    gen_nin = clamp_count(int'(INPUT_COUNT_RST), N_IN);
    gen_fcount = 0;
    gen_hi = 0;

    // nothing trained yet: the epoch is converged
    push_epoch();
    push_cfg(REG_LEARNING_RATE, 16'hFFFF);
    push_cfg(REG_INPUT_COUNT, 16'hFFE2);
    push_cfg(REG_OUTPUT_COUNT, 16'hFFF1);
    // drive neuron 0 into the upper weight limit
    push_weight(0, 0, 32'h7FFF_FF00);
    push_weight(0, 1, 32'h7FFF_FFFF);
    push_weight(0, 3, 32'h1234_5678);
    push_feature(ACT_TRAIN, 16'h7FFF, 8'h00, 1'b0);
    push_feature(ACT_TRAIN, 16'h8000, 8'hFF, 1'b1);
    // and into the lower one
    push_weight(0, 0, 32'h8000_0100);
    push_weight(0, 1, 32'h8000_0000);
    push_feature(ACT_TRAIN, 16'h7FFF, 8'h00, 1'b0);
    push_feature(ACT_TRAIN, 16'h8000, 8'hFE, 1'b1);
    // drop a partial sample at epoch end; mix modes around a bias write
    push_feature(ACT_RECALL, 16'h0100, 8'h00, 1'b0);
    push_epoch();
    push_feature(ACT_TRAIN, 16'h0100, 8'h00, 1'b0);
    push_weight(0, 2, 32'h0001_0000);
    push_feature(ACT_RECALL, 16'hFF00, 8'h01, 1'b1);
    push_epoch();
    // zero rate, counts clamped from both ends
    push_cfg(REG_LEARNING_RATE, 16'h0000);
    push_cfg(REG_INPUT_COUNT, 16'h0000);
    push_cfg(REG_OUTPUT_COUNT, 16'h000F);
    push_weight(7, 1, 32'h8000_0000);
    push_feature(ACT_TRAIN, 16'h7FFF, 8'h00, 1'b1);
    push_epoch();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: rate = 16'hFFFF;
        1: rate = 16'($urandom);
        2: rate = 16'($urandom_range(1, 2000));
        default: rate = LEARNING_RATE_RST;
      endcase
      push_cfg(REG_LEARNING_RATE, rate);
      if (p == 3) nin_raw = 5'd16;
      else if ($urandom_range(0, 4) == 0) nin_raw = 5'($urandom_range(0, 31));
      else nin_raw = 5'($urandom_range(1, 4));
      r16 = 16'($urandom);
      push_cfg(REG_INPUT_COUNT, {r16[15:5], nin_raw});
      r16 = 16'($urandom);
      push_cfg(REG_OUTPUT_COUNT, {r16[15:4], 4'($urandom_range(0, 15))});
      for (int i = 0; i < 12; i++)
        push_weight($urandom_range(0, 7), $urandom_range(0, gen_nin), rand_weight());
      phase_end = cmd_q.size() + 58;
      while (cmd_q.size() < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)
          push_weight($urandom_range(0, 7),
                      pick < 3 ? $urandom_range(0, 31) : $urandom_range(0, gen_nin),
                      rand_weight());
        else if (pick < 14)
          push_epoch();
        else if (pick < 20)
          push_feature(2'($urandom_range(1, 2)), rand_feature(), 8'($urandom),
                       1'($urandom_range(0, 1)));
        else
          push_sample(pick < 60 ? ACT_TRAIN : ACT_RECALL,
                      pick >= 92 ? $urandom_range(1, 20) : gen_nin);
      end
      push_epoch();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start || pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
